[rtl/assert_macros.svh]
// Assertion helpers shared by the renderer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define TCGR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tcgr assertion failed");

// Next-cycle implication, disabled while reset is active.
`define TCGR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tcgr assertion failed");

`endif

[rtl/tcgr_pkg.sv]
`timescale 1ns / 1ps
package tcgr_pkg;

    // Field and register widths
    localparam int CUR_W     = 12;
    localparam int CFG_W     = 12;
    localparam int CODE_W    = 8;
    localparam int GLYPH_W   = 64;
    localparam int PIX_W     = 11;
    localparam int ADDR_W    = 22;
    localparam int COORD_W   = 14;
    localparam int IDX_W     = 6;
    localparam int CFG_IDX_W = 2;

    // Default sizing
    localparam int GLYPH_COUNT_DEF = 256;
    localparam int MAX_DIM_DEF     = 2048;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Codes
    localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic              MODE_DRAW    = 1'b0;
    localparam logic              MODE_LOAD    = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_START_X      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd3;

    localparam logic signed [CUR_W-1:0] CURSOR_MAX   = 12'sd2047;
    localparam logic [CFG_W-1:0]        WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0]        HEIGHT_RESET = 12'd480;

    // One character handed from front to back
    typedef struct packed {
        logic [GLYPH_W-1:0]      glyph;
        logic signed [CUR_W-1:0] cx;
        logic signed [CUR_W-1:0] cy;
    } tcgr_item_t;

    // Add 8 to a cursor coordinate, saturating at the top
    function automatic logic signed [CUR_W-1:0] sat_add8(input logic signed [CUR_W-1:0] v);
        logic signed [CUR_W:0] sum;
        sum = (CUR_W+1)'(v) + (CUR_W+1)'(8);
        if (sum > (CUR_W+1)'(CURSOR_MAX)) begin
            return CURSOR_MAX;
        end
        return sum[CUR_W-1:0];
    endfunction

endpackage

[rtl/tcgr_ram.sv]
`timescale 1ns / 1ps
module tcgr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one word, register the read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/tcgr_front.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tcgr_front
    import tcgr_pkg::*;
#(
    parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
    parameter int MAX_DIM     = MAX_DIM_DEF,
    parameter int DIM_W       = $clog2(MAX_DIM + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 mode,
    input  logic [CODE_W-1:0]    char_code,
    input  logic [GLYPH_W-1:0]   glyph_bits,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 q_push,
    output tcgr_item_t           q_item,
    input  logic                 q_full,
    output logic [DIM_W-1:0]     w_eff,
    output logic [DIM_W-1:0]     h_eff
);

    localparam int GA_W = $clog2(GLYPH_COUNT);
    localparam int DC_W = (DIM_W > CFG_W) ? DIM_W : CFG_W;

    logic signed [CUR_W-1:0] start_x_reg, start_x_next;
    logic signed [CUR_W-1:0] start_y_reg, start_y_next;
    logic [CFG_W-1:0]        width_reg, width_next;
    logic [CFG_W-1:0]        height_reg, height_next;
    logic signed [CUR_W-1:0] cursor_x_reg, cursor_x_next;
    logic signed [CUR_W-1:0] cursor_y_reg, cursor_y_next;
    logic                    stage_valid_reg, stage_valid_next;
    logic signed [CUR_W-1:0] stage_cx_reg, stage_cx_next;
    logic signed [CUR_W-1:0] stage_cy_reg, stage_cy_next;

    logic             accept;
    logic             code_ok;
    logic             cfg_write;
    logic             ram_we;
    logic [GA_W-1:0]  glyph_addr;
    logic [GLYPH_W-1:0] ram_rdata;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign in_ready  = !stage_valid_reg && !q_full;
    assign accept    = in_valid && in_ready;
    assign code_ok   = {1'b0, char_code} < (CODE_W+1)'(GLYPH_COUNT);
    assign glyph_addr = char_code[GA_W-1:0];
    assign ram_we    = accept && (mode == MODE_LOAD) && code_ok;

    // Glyph store: written by load words, read for every draw word
    tcgr_ram #(
        .WIDTH (GLYPH_W),
        .DEPTH (GLYPH_COUNT)
    ) u_glyph_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (glyph_addr),
        .wdata (glyph_bits),
        .raddr (glyph_addr),
        .rdata (ram_rdata)
    );

    // Cap image size at MAX_DIM
    always_comb
    begin
        if (DC_W'(width_reg) > DC_W'(MAX_DIM))
        begin
            w_eff = DIM_W'(MAX_DIM);
        end
        else
        begin
            w_eff = DIM_W'(width_reg);
        end
        if (DC_W'(height_reg) > DC_W'(MAX_DIM))
        begin
            h_eff = DIM_W'(MAX_DIM);
        end
        else
        begin
            h_eff = DIM_W'(height_reg);
        end
    end

    // Classify words, move the cursor, snapshot it for draws
    always_comb
    begin
        start_x_next     = start_x_reg;
        start_y_next     = start_y_reg;
        width_next       = width_reg;
        height_next      = height_reg;
        cursor_x_next    = cursor_x_reg;
        cursor_y_next    = cursor_y_reg;
        stage_valid_next = 1'b0;
        stage_cx_next    = stage_cx_reg;
        stage_cy_next    = stage_cy_reg;

        if (accept && (mode == MODE_DRAW))
        begin
            if (char_code == NEWLINE_CODE)
            begin
                cursor_x_next = start_x_reg;
                cursor_y_next = sat_add8(cursor_y_reg);
            end
            else
            begin
                cursor_x_next    = sat_add8(cursor_x_reg);
                stage_valid_next = code_ok;
                stage_cx_next    = cursor_x_reg;
                stage_cy_next    = cursor_y_reg;
            end
        end

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_START_X:
                begin
                    start_x_next  = $signed(cfg_data);
                    cursor_x_next = $signed(cfg_data);
                end
                CFG_START_Y:
                begin
                    start_y_next  = $signed(cfg_data);
                    cursor_y_next = $signed(cfg_data);
                end
                CFG_IMAGE_WIDTH:  width_next  = cfg_data;
                CFG_IMAGE_HEIGHT: height_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg     <= '0;
            start_y_reg     <= '0;
            width_reg       <= WIDTH_RESET;
            height_reg      <= HEIGHT_RESET;
            cursor_x_reg    <= '0;
            cursor_y_reg    <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            start_x_reg     <= start_x_next;
            start_y_reg     <= start_y_next;
            width_reg       <= width_next;
            height_reg      <= height_next;
            cursor_x_reg    <= cursor_x_next;
            cursor_y_reg    <= cursor_y_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_cx_reg <= stage_cx_next;
        stage_cy_reg <= stage_cy_next;
    end

    // Hand the glyph and cursor snapshot to the queue once the read returns
    assign q_push       = stage_valid_reg;
    assign q_item.glyph = ram_rdata;
    assign q_item.cx    = stage_cx_reg;
    assign q_item.cy    = stage_cy_reg;

    `TCGR_ASSERT_NEXT(a_draw_stages, clk, rst_n,
        accept && (mode == MODE_DRAW) && (char_code != NEWLINE_CODE) && code_ok,
        stage_valid_reg && !in_ready)
    `TCGR_ASSERT_NOW(a_push_has_room, clk, rst_n, q_push, !q_full)

endmodule

[rtl/tcgr_queue.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tcgr_queue
    import tcgr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  tcgr_item_t push_item,
    input  logic       pop,
    output tcgr_item_t head_item,
    output logic       empty,
    output logic       full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tcgr_item_t        slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign head_item = slot_reg[rd_ptr_reg];

    // Advance pointers with wrap, track fill
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    `TCGR_ASSERT_NOW(a_no_overflow, clk, rst_n, push, !full)
    `TCGR_ASSERT_NOW(a_no_underflow, clk, rst_n, pop, !empty)

endmodule

[rtl/tcgr_back.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tcgr_back
    import tcgr_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF,
    parameter int DIM_W   = $clog2(MAX_DIM + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [DIM_W-1:0]  w_eff,
    input  logic [DIM_W-1:0]  h_eff,
    input  tcgr_item_t        head_item,
    input  logic              q_empty,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [PIX_W-1:0]  pixel_x,
    output logic [PIX_W-1:0]  pixel_y,
    output logic [ADDR_W-1:0] pixel_addr,
    output logic              last
);

    localparam int POS_W = COORD_W - 2;
    localparam int SUM_W = (POS_W + DIM_W > ADDR_W) ? POS_W + DIM_W : ADDR_W;

    logic                    busy_reg, busy_next;
    logic [GLYPH_W-1:0]      mask_reg, mask_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic signed [CUR_W-1:0] cx_reg, cx_next;
    logic signed [CUR_W-1:0] cy_reg, cy_next;
    logic                    out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]        pixel_x_reg, pixel_x_next;
    logic [PIX_W-1:0]        pixel_y_reg, pixel_y_next;
    logic [ADDR_W-1:0]       pixel_addr_reg, pixel_addr_next;
    logic                    last_reg, last_next;

    logic [7:0]              col_ok;
    logic [7:0]              row_ok;
    logic [GLYPH_W-1:0]      vis_mask;
    logic [GLYPH_W-1:0]      mask_shift;
    logic                    out_free;
    logic                    emit;
    logic                    step;
    logic signed [COORD_W-1:0] px_s;
    logic signed [COORD_W-1:0] py_s;
    logic [SUM_W-1:0]        addr_sum;

    // Per-column and per-row clip of the incoming character
    always_comb
    begin
        logic signed [COORD_W-1:0] cpos;
        logic signed [COORD_W-1:0] rpos;
        for (int k = 0; k < 8; k++)
        begin
            cpos = COORD_W'(head_item.cx) + COORD_W'(k);
            rpos = COORD_W'(head_item.cy) + COORD_W'(k);
            col_ok[k] = (cpos >= 0) && (cpos < $signed({{(COORD_W-DIM_W){1'b0}}, w_eff}));
            row_ok[k] = (rpos >= 0) && (rpos < $signed({{(COORD_W-DIM_W){1'b0}}, h_eff}));
        end
    end

    // Keep only set glyph bits that land inside the image
    always_comb
    begin
        for (int r = 0; r < 8; r++)
        begin
            for (int c = 0; c < 8; c++)
            begin
                vis_mask[GLYPH_W-1-(r*8+c)] =
                    head_item.glyph[GLYPH_W-1-(r*8+c)] && row_ok[r] && col_ok[c];
            end
        end
    end

    assign q_pop      = !busy_reg && !q_empty;
    assign out_free   = !out_valid_reg || out_ready;
    assign emit       = busy_reg && mask_reg[GLYPH_W-1] && out_free;
    assign step       = busy_reg && (!mask_reg[GLYPH_W-1] || out_free);
    assign mask_shift = {mask_reg[GLYPH_W-2:0], 1'b0};

    // Pixel coordinate and linear address of the current bit
    assign px_s = COORD_W'(cx_reg) + $signed({{(COORD_W-3){1'b0}}, idx_reg[2:0]});
    assign py_s = COORD_W'(cy_reg) + $signed({{(COORD_W-3){1'b0}}, idx_reg[5:3]});
    assign addr_sum = SUM_W'(py_s[POS_W-1:0]) * SUM_W'(w_eff) + SUM_W'(px_s[POS_W-1:0]);

    // Walk the mask one bit a cycle, stall on a set bit while the output is held
    always_comb
    begin
        busy_next       = busy_reg;
        mask_next       = mask_reg;
        idx_next        = idx_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        pixel_x_next    = pixel_x_reg;
        pixel_y_next    = pixel_y_reg;
        pixel_addr_next = pixel_addr_reg;
        last_next       = last_reg;

        if (q_pop)
        begin
            busy_next = |vis_mask;
            mask_next = vis_mask;
            idx_next  = '0;
            cx_next   = head_item.cx;
            cy_next   = head_item.cy;
        end
        else if (step)
        begin
            busy_next = |mask_shift;
            mask_next = mask_shift;
            idx_next  = idx_reg + 1'b1;
        end

        if (emit)
        begin
            out_valid_next  = 1'b1;
            pixel_x_next    = px_s[PIX_W-1:0];
            pixel_y_next    = py_s[PIX_W-1:0];
            pixel_addr_next = addr_sum[ADDR_W-1:0];
            last_next       = (mask_reg[GLYPH_W-2:0] == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg       <= mask_next;
        idx_reg        <= idx_next;
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        pixel_x_reg    <= pixel_x_next;
        pixel_y_reg    <= pixel_y_next;
        pixel_addr_reg <= pixel_addr_next;
        last_reg       <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign pixel_x    = pixel_x_reg;
    assign pixel_y    = pixel_y_reg;
    assign pixel_addr = pixel_addr_reg;
    assign last       = last_reg;

    `TCGR_ASSERT_NOW(a_busy_has_bits, clk, rst_n, busy_reg, mask_reg != '0)
    `TCGR_ASSERT_NEXT(a_last_ends_char, clk, rst_n, emit && last_next, !busy_reg)

endmodule

[rtl/text_cursor_glyph_renderer.sv]
`timescale 1ns / 1ps
// 8x8 bitmap text renderer. A load word (mode 1) stores a 64-bit glyph, MSB at
// the top left, at index char_code; a draw word (mode 0) emits one pixel word
// per set glyph bit inside the image, row-major, at the cursor plus the bit's
// offset, with last on the final one, then moves the cursor right by 8; char
// code 0x0A is a newline (x back to start_x, y down by 8, no pixels). Cursor
// steps saturate at 2047, and writing start_x or start_y also moves the cursor.
// Glyph memory has no reset: draw only glyphs already loaded. A draw passes
// through the glyph memory read in the front, which takes no new word while
// the read is staged; the pixel walker then picks it up from the queue and
// steps one glyph bit position at a time up to the last visible set bit,
// holding on each output stall. A two-entry queue lets the front keep taking
// words while the walker draws. Change configuration only while the block is
// idle.
module text_cursor_glyph_renderer
    import tcgr_pkg::*;
#(
    parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
    parameter int MAX_DIM     = MAX_DIM_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 mode,
    input  logic [CODE_W-1:0]    char_code,
    input  logic [GLYPH_W-1:0]   glyph_bits,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [PIX_W-1:0]     pixel_x,
    output logic [PIX_W-1:0]     pixel_y,
    output logic [ADDR_W-1:0]    pixel_addr,
    output logic                 last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);

    tcgr_item_t       push_item;
    tcgr_item_t       head_item;
    logic             q_push;
    logic             q_pop;
    logic             q_empty;
    logic             q_full;
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;

    // Classify words, hold cursor and glyph memory
    tcgr_front #(
        .GLYPH_COUNT (GLYPH_COUNT),
        .MAX_DIM     (MAX_DIM),
        .DIM_W       (DIM_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .char_code  (char_code),
        .glyph_bits (glyph_bits),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_push     (q_push),
        .q_item     (push_item),
        .q_full     (q_full),
        .w_eff      (w_eff),
        .h_eff      (h_eff)
    );

    // Buffer characters between front and walker
    tcgr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .empty     (q_empty),
        .full      (q_full)
    );

    // Walk glyph bits and emit pixel words
    tcgr_back #(
        .MAX_DIM (MAX_DIM),
        .DIM_W   (DIM_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .w_eff      (w_eff),
        .h_eff      (h_eff),
        .head_item  (head_item),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .pixel_addr (pixel_addr),
        .last       (last)
    );

endmodule

[test/tb_text_cursor_glyph_renderer.sv]
`timescale 1ns / 1ps
module tb_text_cursor_glyph_renderer;
    import tcgr_pkg::*;

    localparam int SETTLE_CYCLES = 250;
    localparam int LONG_STALL    = 400;

    typedef struct packed {
        logic               m;
        logic [CODE_W-1:0]  code;
        logic [GLYPH_W-1:0] bits;
    } char_word_t;

    typedef struct packed {
        logic [PIX_W-1:0]  x;
        logic [PIX_W-1:0]  y;
        logic [ADDR_W-1:0] addr;
        logic              fin;
    } pixel_word_t;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic                 in_ready;
    logic                 mode       = MODE_DRAW;
    logic [CODE_W-1:0]    char_code  = '0;
    logic [GLYPH_W-1:0]   glyph_bits = '0;
    logic                 out_valid;
    logic                 out_ready  = 1'b0;
    logic [PIX_W-1:0]     pixel_x;
    logic [PIX_W-1:0]     pixel_y;
    logic [ADDR_W-1:0]    pixel_addr;
    logic                 last;
    logic                 cfg_valid  = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index  = CFG_START_X;
    logic [CFG_W-1:0]     cfg_data   = '0;

    // Renderer shadow state
    logic signed [CUR_W-1:0] margin_x = '0;
    logic signed [CUR_W-1:0] top_y    = '0;
    logic [CFG_W-1:0]        img_w    = WIDTH_RESET;
    logic [CFG_W-1:0]        img_h    = HEIGHT_RESET;
    logic signed [CUR_W-1:0] cur_x    = '0;
    logic signed [CUR_W-1:0] cur_y    = '0;
    logic [GLYPH_W-1:0]      font_rom [256];

    char_word_t  pending_chars[$];
    pixel_word_t pixels_due[$];
    logic [CODE_W-1:0] loaded_codes[$];
    bit          glyph_known [256];
    char_word_t  next_char;
    pixel_word_t due_px;

    int send_gap          = 0;
    int hold_left         = 0;
    int recv_wait         = 0;
    int mismatch_count    = 0;
    bit send_burst        = 1'b0;
    bit recv_burst        = 1'b0;
    bit long_stall_armed  = 1'b0;
    bit long_stall_served = 1'b0;

    text_cursor_glyph_renderer u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .char_code  (char_code),
        .glyph_bits (glyph_bits),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .pixel_addr (pixel_addr),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #4 clk = ~clk;

    // Cursor step of 8, clamped at the top coordinate
    function automatic logic signed [CUR_W-1:0] step8(input logic signed [CUR_W-1:0] v);
        int s;
        s = int'(v) + 8;
        if (s > 2047)
        begin
            s = 2047;
        end
        return CUR_W'(s);
    endfunction

    // Apply one accepted word to the shadow state and queue its pixel writes
    task automatic render_word(input logic m, input logic [CODE_W-1:0] code,
                               input logic [GLYPH_W-1:0] bits);
        pixel_word_t strokes[$];
        pixel_word_t pw;
        logic [GLYPH_W-1:0] g;
        int wdt;
        int hgt;
        int px;
        int py;
        wdt = (img_w > 12'd2048) ? 2048 : int'(img_w);
        hgt = (img_h > 12'd2048) ? 2048 : int'(img_h);
        if (m == MODE_LOAD)
        begin
            font_rom[code] = bits;
        end
        else if (code == NEWLINE_CODE)
        begin
            cur_x = margin_x;
            cur_y = step8(cur_y);
        end
        else
        begin
            g = font_rom[code];
            for (int r = 0; r < 8; r++)
            begin
                for (int c = 0; c < 8; c++)
                begin
                    px = int'(cur_x) + c;
                    py = int'(cur_y) + r;
                    if (g[63 - (r * 8 + c)] && px >= 0 && px < wdt && py >= 0 && py < hgt)
                    begin
                        pw.x    = px[PIX_W-1:0];
                        pw.y    = py[PIX_W-1:0];
                        pw.addr = ADDR_W'(py * wdt + px);
                        pw.fin  = 1'b0;
                        strokes.push_back(pw);
                    end
                end
            end
            // Flag the final visible pixel
            if (strokes.size() != 0)
            begin
                strokes[strokes.size() - 1].fin = 1'b1;
            end
            foreach (strokes[i])
            begin
                pixels_due.push_back(strokes[i]);
            end
            cur_x = step8(cur_x);
        end
    endtask

    // Sender: offer queued words, with a random gap after each unless bursting
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                render_word(mode, char_code, glyph_bits);
            end
            if (in_valid && !in_ready)
            begin
                // hold the word until taken
            end
            else if (send_gap != 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_chars.size() != 0)
            begin
                next_char  = pending_chars.pop_front();
                mode       <= next_char.m;
                char_code  <= next_char.code;
                glyph_bits <= next_char.bits;
                in_valid   <= 1'b1;
                send_gap   <= send_burst ? 0 : $urandom_range(0, 4);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: check each pixel word, then stall at random unless bursting
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else if (out_valid && out_ready)
        begin
            if (pixels_due.size() == 0)
            begin
                $display("%0t: unexpected pixel word x=%0d y=%0d addr=%0d last=%0b",
                         $time, pixel_x, pixel_y, pixel_addr, last);
                mismatch_count++;
            end
            else
            begin
                due_px = pixels_due.pop_front();
                if (pixel_x !== due_px.x)
                begin
                    $display("%0t: pixel_x expected %0d actual %0d", $time, due_px.x, pixel_x);
                    mismatch_count++;
                end
                if (pixel_y !== due_px.y)
                begin
                    $display("%0t: pixel_y expected %0d actual %0d", $time, due_px.y, pixel_y);
                    mismatch_count++;
                end
                if (pixel_addr !== due_px.addr)
                begin
                    $display("%0t: pixel_addr expected %0d actual %0d",
                             $time, due_px.addr, pixel_addr);
                    mismatch_count++;
                end
                if (last !== due_px.fin)
                begin
                    $display("%0t: last expected %0b actual %0b", $time, due_px.fin, last);
                    mismatch_count++;
                end
            end
            if (!recv_burst)
            begin
                recv_wait = $urandom_range(0, 4);
                hold_left <= recv_wait;
                out_ready <= (recv_wait == 0);
            end
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= (hold_left == 1);
        end
        else if (long_stall_armed && !long_stall_served)
        begin
            // back up the output so the input side fills
            long_stall_served <= 1'b1;
            hold_left         <= LONG_STALL;
            out_ready         <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    task automatic add_word(input logic m, input logic [CODE_W-1:0] code,
                            input logic [GLYPH_W-1:0] bits);
        char_word_t cw;
        cw.m    = m;
        cw.code = code;
        cw.bits = bits;
        pending_chars.push_back(cw);
        if (m == MODE_LOAD && !glyph_known[code])
        begin
            glyph_known[code] = 1'b1;
            loaded_codes.push_back(code);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            CFG_START_X:
            begin
                margin_x = data;
                cur_x    = data;
            end
            CFG_START_Y:
            begin
                top_y = data;
                cur_y = data;
            end
            CFG_IMAGE_WIDTH:  img_w = data;
            CFG_IMAGE_HEIGHT: img_h = data;
            default: ;
        endcase
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] sx, input logic [CFG_W-1:0] sy,
                             input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        write_reg(CFG_START_X, sx);
        write_reg(CFG_START_Y, sy);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    // Drain: all words taken, all pixels seen, then let trailing work finish
    task automatic wait_idle();
        while (pending_chars.size() != 0 || in_valid || pixels_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_origin();
        case ($urandom_range(0, 6))
            0:       return 12'h800;
            1:       return 12'h7FF;
            2:       return CFG_W'($urandom);
            3:       return CFG_W'($urandom_range(0, 24)) - 12'd12;
            default: return CFG_W'($urandom_range(0, 40));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_extent();
        case ($urandom_range(0, 5))
            0:       return 12'd1;
            1:       return 12'd2048;
            2:       return CFG_W'($urandom_range(1, 2048));
            3:       return CFG_W'($urandom_range(2, 64));
            default: return CFG_W'($urandom_range(40, 700));
        endcase
    endfunction

    initial
    begin
        int sel;
        logic [GLYPH_W-1:0] g;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset geometry: solid, corner, empty and checker glyphs
        add_word(MODE_LOAD, 8'h00, '1);
        add_word(MODE_LOAD, 8'hFF, 64'h8000_0000_0000_0001);
        add_word(MODE_LOAD, NEWLINE_CODE, 64'hFF00_0000_0000_00FF);
        add_word(MODE_LOAD, 8'h55, '0);
        add_word(MODE_LOAD, 8'hAA, 64'hAA55_AA55_AA55_AA55);
        add_word(MODE_DRAW, 8'h00, {$urandom, $urandom});
        add_word(MODE_DRAW, 8'hFF, {$urandom, $urandom});
        add_word(MODE_DRAW, 8'h55, {$urandom, $urandom});
        add_word(MODE_DRAW, 8'hAA, {$urandom, $urandom});
        add_word(MODE_DRAW, NEWLINE_CODE, {$urandom, $urandom});
        add_word(MODE_DRAW, 8'h00, {$urandom, $urandom});
        wait_idle();

        // Clip on all four sides of a tiny image
        set_frame(12'hFFC, 12'hFFC, 12'd10, 12'd6);
        add_word(MODE_DRAW, 8'h00, '0);
        add_word(MODE_DRAW, 8'h00, '1);
        add_word(MODE_DRAW, NEWLINE_CODE, '0);
        add_word(MODE_DRAW, 8'h00, '0);
        add_word(MODE_DRAW, 8'hAA, '0);
        wait_idle();

        // Far corner of the largest image, cursor clamps at the top
        set_frame(12'd2040, 12'd2040, 12'd2048, 12'd2048);
        add_word(MODE_DRAW, 8'h00, '0);
        add_word(MODE_DRAW, 8'h00, '0);
        add_word(MODE_DRAW, 8'h00, '0);
        add_word(MODE_DRAW, NEWLINE_CODE, '0);
        add_word(MODE_DRAW, 8'hFF, '0);
        wait_idle();

        // One-pixel image
        set_frame(12'd0, 12'd0, 12'd1, 12'd1);
        add_word(MODE_DRAW, 8'h00, '0);
        add_word(MODE_DRAW, 8'hFF, '0);
        wait_idle();

        // Most negative origin, nothing visible
        set_frame(12'h800, 12'h800, 12'd2048, 12'd2048);
        add_word(MODE_DRAW, 8'h00, '0);
        add_word(MODE_DRAW, NEWLINE_CODE, '0);
        wait_idle();

        // Stall the output while the sender keeps pushing full glyphs
        send_burst = 1'b1;
        set_frame(12'd0, 12'd0, WIDTH_RESET, HEIGHT_RESET);
        long_stall_armed = 1'b1;
        repeat (12) add_word(MODE_DRAW, 8'h00, {$urandom, $urandom});
        wait_idle();

        // Random geometry and text runs
        for (int ph = 0; ph < 6; ph++)
        begin
            send_burst = ($urandom_range(0, 2) == 0);
            recv_burst = ($urandom_range(0, 2) == 0);
            set_frame(pick_origin(), pick_origin(), pick_extent(), pick_extent());
            for (int k = 0; k < 12; k++)
            begin
                g = {$urandom, $urandom};
                case ($urandom_range(0, 4))
                    0: g = g & {$urandom, $urandom};
                    1: g = '1;
                    2: g = 64'd1 << $urandom_range(0, 63);
                    default: ;
                endcase
                sel = $urandom_range(0, 99);
                if (sel < 20)
                begin
                    add_word(MODE_LOAD, CODE_W'($urandom), g);
                end
                else if (sel < 30)
                begin
                    add_word(MODE_DRAW, NEWLINE_CODE, g);
                end
                else
                begin
                    add_word(MODE_DRAW,
                             loaded_codes[$urandom_range(0, loaded_codes.size() - 1)], g);
                end
            end
            wait_idle();
        end

        if (mismatch_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/tcgr_pkg.sv
rtl/tcgr_ram.sv
rtl/tcgr_front.sv
rtl/tcgr_queue.sv
rtl/tcgr_back.sv
rtl/text_cursor_glyph_renderer.sv
test/tb_text_cursor_glyph_renderer.sv
